// ===== design/rpnc_pkg.sv =====
// Package with shared types and constants of the RPN stack calculator.
package rpnc_pkg;

   localparam int StackDepth = 64;
   localparam int FracBits   = 16;
   localparam int AddrWidth  = $clog2(StackDepth);
   localparam int DepthWidth = 7;

   typedef enum logic [3:0] {
      ACT_PUSH  = 4'd0,
      ACT_ADD   = 4'd1,
      ACT_SUB   = 4'd2,
      ACT_MUL   = 4'd3,
      ACT_DIV   = 4'd4,
      ACT_REM   = 4'd5,
      ACT_POP   = 4'd6,
      ACT_PEEK  = 4'd7,
      ACT_DUP   = 4'd8,
      ACT_SWAP  = 4'd9,
      ACT_CLEAR = 4'd10
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_DIVZERO   = 2'd3
   } status_type;

   // Datapath operations issued by the controller.
   typedef enum logic [2:0] {
      DP_NONE,
      DP_ADD,
      DP_SUB,
      DP_MUL,
      DP_DIV_START,
      DP_DIV_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type           op;
      logic                rem_sel;
      logic                load_a;
      logic                load_b;
   } dp_cmd_type;

   typedef struct packed {
      logic                div_done;
      logic                b_zero;
   } dp_stat_type;

endpackage

// ===== design/rpnc_ram.sv =====
// Generic single-port RAM with registered read.
module rpnc_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // Write port and registered read share one address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

// ===== design/rpnc_datapath.sv =====
// Arithmetic datapath: operand registers, saturating add and subtract, multiply and divider.
module rpnc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rpnc_pkg::dp_cmd_type cmd,
   input  logic [31:0]          rd_data,
   output rpnc_pkg::dp_stat_type stat,
   output logic [31:0]          result
);

   localparam int NumW = 32 + rpnc_pkg::FracBits;
   localparam int CntW = $clog2(NumW + 1);

   logic signed [31:0] a_ff, b_ff;
   logic [31:0]        res_ff, res_in;
   logic [NumW-1:0]    quo_ff, quo_in;
   logic [32:0]        rem_ff, rem_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic               busy_ff, busy_in;
   logic [31:0]        mag_a, mag_b;
   logic signed [32:0] sum;
   logic [63:0]        prod;
   logic [63:0]        prod_sh;
   logic [33:0]        trial;
   logic [NumW:0]      q_ext;

   assign mag_a = a_ff[31] ? 32'(-a_ff) : a_ff;
   assign mag_b = b_ff[31] ? 32'(-b_ff) : b_ff;
   assign prod    = mag_a * mag_b;
   assign prod_sh = prod >> rpnc_pkg::FracBits;
   assign trial   = {rem_ff, quo_ff[NumW-1]} - {2'b00, mag_b};
   assign q_ext   = {1'b0, quo_ff};

   // Saturate a magnitude with a sign into the signed 32-bit range.
   function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] m);
      logic [31:0] r;
      if (neg) begin
         r = (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-m);
      end else begin
         r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
      end
      return r;
   endfunction

   always_comb begin
      res_in  = res_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      sum     = '0;
      case (cmd.op)
         rpnc_pkg::DP_ADD: begin
            sum = 33'(a_ff) + 33'(b_ff);
            res_in = (sum > 33'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
                     (sum < -33'sh8000_0000) ? 32'h8000_0000 : sum[31:0];
         end
         rpnc_pkg::DP_SUB: begin
            sum = 33'(a_ff) - 33'(b_ff);
            res_in = (sum > 33'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
                     (sum < -33'sh8000_0000) ? 32'h8000_0000 : sum[31:0];
         end
         rpnc_pkg::DP_MUL: begin
            res_in = sat_mag(a_ff[31] ^ b_ff[31], prod_sh);
         end
         rpnc_pkg::DP_DIV_START: begin
            // Dividend is |a| shifted by the fraction bits for divide, raw for remainder.
            quo_in  = cmd.rem_sel ? NumW'(mag_a) : {mag_a, {rpnc_pkg::FracBits{1'b0}}};
            rem_in  = '0;
            cnt_in  = CntW'(NumW);
            neg_in  = cmd.rem_sel ? a_ff[31] : (a_ff[31] ^ b_ff[31]);
            busy_in = 1'b1;
         end
         rpnc_pkg::DP_DIV_STEP: begin
            if (busy_ff) begin
               // One restoring division step per cycle.
               if (!trial[33]) begin
                  rem_in = trial[32:0];
                  quo_in = {quo_ff[NumW-2:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[31:0], quo_ff[NumW-1]};
                  quo_in = {quo_ff[NumW-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CntW'(1)) begin
                  busy_in = 1'b0;
               end
            end else begin
               res_in = cmd.rem_sel ? sat_mag(neg_ff, {31'b0, rem_ff}) :
                        sat_mag(neg_ff, 64'(q_ext));
            end
         end
         default: ;
      endcase
   end

   // Operand loads come from the stack RAM read port.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      if (cmd.load_a) a_ff <= rd_data;
      if (cmd.load_b) b_ff <= rd_data;
      res_ff <= res_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign stat.div_done = !busy_ff;
   assign stat.b_zero   = (b_ff == 32'd0);
   assign result        = res_ff;

endmodule

// ===== design/rpnc_ctrl.sv =====
// Controller state machine: stack pointer, RAM sequencing and result strobe.
module rpnc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [3:0]                    req_action,
   input  logic [31:0]                   req_operand_value,
   output logic                          busy,
   output logic                          rsp_valid,
   output logic [31:0]                   rsp_result_value,
   output logic [1:0]                    rsp_status,
   output logic [6:0]                    rsp_depth,
   output rpnc_pkg::dp_cmd_type          cmd,
   input  rpnc_pkg::dp_stat_type         stat,
   input  logic [31:0]                   dp_result,
   output logic                          ram_we,
   output logic [rpnc_pkg::AddrWidth-1:0] ram_addr,
   output logic [31:0]                   ram_wdata,
   input  logic [31:0]                   ram_rdata
);

   localparam int AW = rpnc_pkg::AddrWidth;
   localparam int DW = rpnc_pkg::DepthWidth;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_B, S_RD_A, S_LOAD_A, S_EXEC, S_DIV, S_WRITE,
      S_RD_TOP, S_TOP, S_SWAP_W1, S_SWAP_W2, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [3:0]       act_ff, act_in;
   logic [31:0]      val_ff, val_in;
   logic [DW-1:0]    dep_ff, dep_in;
   logic [1:0]       st_ff, st_in;
   logic [31:0]      out_ff, out_in;
   logic             vld_ff, vld_in;
   logic [31:0]      tmp_ff, tmp_in;

   // Next state, stack pointer and RAM accesses.
   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      val_in    = val_ff;
      dep_in    = dep_ff;
      st_in     = st_ff;
      out_in    = out_ff;
      vld_in    = 1'b0;
      tmp_in    = tmp_ff;
      cmd       = '{op: rpnc_pkg::DP_NONE, rem_sel: 1'b0, load_a: 1'b0, load_b: 1'b0};
      cmd.rem_sel = (act_ff == rpnc_pkg::ACT_REM);
      ram_we    = 1'b0;
      ram_addr  = AW'(dep_ff - 1'b1);
      ram_wdata = val_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in = req_action;
               val_in = req_operand_value;
               st_in  = rpnc_pkg::ST_OK;
               if (req_action inside {rpnc_pkg::ACT_ADD, rpnc_pkg::ACT_SUB,
                      rpnc_pkg::ACT_MUL, rpnc_pkg::ACT_DIV, rpnc_pkg::ACT_REM,
                      rpnc_pkg::ACT_SWAP}) begin
                  if (dep_ff < DW'(2)) begin
                     st_in = rpnc_pkg::ST_UNDERFLOW;
                     state_in = S_RD_TOP;
                  end else begin
                     state_in = S_RD_B;
                  end
               end else if (req_action == rpnc_pkg::ACT_PUSH) begin
                  if (dep_ff >= DW'(rpnc_pkg::StackDepth)) begin
                     st_in = rpnc_pkg::ST_FULL;
                     state_in = S_RD_TOP;
                  end else begin
                     state_in = S_WRITE;
                  end
               end else if (req_action inside {rpnc_pkg::ACT_POP, rpnc_pkg::ACT_PEEK,
                      rpnc_pkg::ACT_DUP}) begin
                  if (dep_ff == '0) begin
                     st_in = rpnc_pkg::ST_UNDERFLOW;
                     state_in = S_RD_TOP;
                  end else if (req_action == rpnc_pkg::ACT_DUP &&
                               dep_ff >= DW'(rpnc_pkg::StackDepth)) begin
                     st_in = rpnc_pkg::ST_FULL;
                     state_in = S_RD_TOP;
                  end else begin
                     state_in = S_RD_B;
                  end
               end else if (req_action == rpnc_pkg::ACT_CLEAR) begin
                  dep_in = '0;
                  state_in = S_RD_TOP;
               end else begin
                  state_in = S_RD_TOP;
               end
            end
         end
         S_RD_B: begin
            // Top entry is presented by the RAM in the next cycle.
            state_in = S_RD_A;
         end
         S_RD_A: begin
            ram_addr = AW'(dep_ff - DW'(2));
            cmd.load_b = 1'b1;
            tmp_in = ram_rdata;
            case (act_ff)
               rpnc_pkg::ACT_POP: begin
                  out_in = ram_rdata;
                  dep_in = dep_ff - 1'b1;
                  state_in = S_DONE;
               end
               rpnc_pkg::ACT_PEEK: begin
                  out_in = ram_rdata;
                  state_in = S_DONE;
               end
               rpnc_pkg::ACT_DUP: begin
                  val_in = ram_rdata;
                  state_in = S_WRITE;
               end
               default: state_in = S_LOAD_A;
            endcase
         end
         S_LOAD_A: begin
            cmd.load_a = 1'b1;
            val_in = ram_rdata;
            if (act_ff == rpnc_pkg::ACT_SWAP) begin
               state_in = S_SWAP_W1;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (act_ff)
               rpnc_pkg::ACT_ADD: begin
                  cmd.op = rpnc_pkg::DP_ADD;
                  state_in = S_DIV;
               end
               rpnc_pkg::ACT_SUB: begin
                  cmd.op = rpnc_pkg::DP_SUB;
                  state_in = S_DIV;
               end
               rpnc_pkg::ACT_MUL: begin
                  cmd.op = rpnc_pkg::DP_MUL;
                  state_in = S_DIV;
               end
               default: begin
                  if (stat.b_zero) begin
                     st_in = rpnc_pkg::ST_DIVZERO;
                     dep_in = dep_ff - 1'b1;
                     state_in = S_RD_TOP;
                  end else begin
                     cmd.op = rpnc_pkg::DP_DIV_START;
                     state_in = S_DIV;
                  end
               end
            endcase
         end
         S_DIV: begin
            // Finished arithmetic result is written over the left operand.
            if (act_ff == rpnc_pkg::ACT_DIV || act_ff == rpnc_pkg::ACT_REM) begin
               cmd.op = rpnc_pkg::DP_DIV_STEP;
               if (stat.div_done) begin
                  state_in = S_TOP;
               end
            end else begin
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            ram_we = 1'b1;
            ram_addr = AW'(dep_ff - DW'(2));
            ram_wdata = dp_result;
            out_in = dp_result;
            dep_in = dep_ff - 1'b1;
            state_in = S_DONE;
         end
         S_WRITE: begin
            ram_we = 1'b1;
            ram_addr = AW'(dep_ff);
            out_in = val_ff;
            dep_in = dep_ff + 1'b1;
            state_in = S_DONE;
         end
         S_SWAP_W1: begin
            ram_we = 1'b1;
            ram_wdata = val_ff;
            state_in = S_SWAP_W2;
         end
         S_SWAP_W2: begin
            ram_we = 1'b1;
            ram_addr = AW'(dep_ff - DW'(2));
            ram_wdata = tmp_ff;
            out_in = val_ff;
            state_in = S_DONE;
         end
         S_RD_TOP: begin
            state_in = S_DONE;
            out_in = '0;
            if (dep_ff != '0) begin
               state_in = S_LOAD_A;
               act_in = rpnc_pkg::ACT_CLEAR;
            end
         end
         S_DONE: begin
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // Read of the top entry after an error, a clear or an unknown action.
      if (state_ff == S_LOAD_A && act_ff == rpnc_pkg::ACT_CLEAR) begin
         cmd.load_a = 1'b0;
         out_in = ram_rdata;
         state_in = S_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dep_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         dep_ff   <= dep_in;
         vld_ff   <= vld_in;
      end
      act_ff <= act_in;
      val_ff <= val_in;
      st_ff  <= st_in;
      out_ff <= out_in;
      tmp_ff <= tmp_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = vld_ff;
   assign rsp_result_value = out_ff;
   assign rsp_status       = st_ff;
   assign rsp_depth        = dep_ff;

endmodule

// ===== design/rpn_stack_calculator_q16_core.sv =====
// Top level of the RPN stack calculator on signed Q16.16 values.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------
//  request  | start, busy              | req_action, req_operand_value
//  response | rsp_valid (one cycle)    | rsp_result_value, rsp_status, rsp_depth
//
// Divide and remainder use the restoring divider, one quotient bit per cycle over
// 48 bits.
// One transaction is in flight at a time; busy stays high until the strobe.
// Synchronous reset empties the stack; the stack RAM itself is not cleared.
// The response cannot be stalled and is shown for exactly one cycle.
module rpn_stack_calculator_q16_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_action,
   input  logic signed [31:0] req_operand_value,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_depth
);

   rpnc_pkg::dp_cmd_type  cmd;
   rpnc_pkg::dp_stat_type stat;
   logic [31:0]           dp_result;
   logic                  ram_we;
   logic [rpnc_pkg::AddrWidth-1:0] ram_addr;
   logic [31:0]           ram_wdata, ram_rdata;

   rpnc_ctrl u_ctrl (
      .clock, .reset, .start, .req_action,
      .req_operand_value(32'(req_operand_value)),
      .busy, .rsp_valid, .rsp_result_value, .rsp_status, .rsp_depth,
      .cmd, .stat, .dp_result, .ram_we, .ram_addr, .ram_wdata, .ram_rdata
   );

   rpnc_datapath u_dp (
      .clock, .reset, .cmd, .rd_data(ram_rdata), .stat, .result(dp_result)
   );

   rpnc_ram #(.Width(32), .Depth(rpnc_pkg::StackDepth)) u_ram (
      .clock, .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   // Depth never exceeds the stack size.
   a_depth_max: assert property (@(posedge clock) disable iff (reset)
      rsp_depth <= 7'(rpnc_pkg::StackDepth))
      else $error("stack depth above limit");

   // A strobe always ends a busy period.
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("response without transaction");

   // A full status never comes with a depth below the limit.
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rpnc_pkg::ST_FULL |-> rsp_depth == 7'(rpnc_pkg::StackDepth))
      else $error("full flagged below limit");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of the RPN stack calculator core.
module tb;

   // One directed stimulus row; chk set means the expected result is typed in.
   typedef struct {
      logic [3:0]           act;
      logic signed [31:0]   val;
      bit                   chk;
      logic signed [31:0]   e_val;
      rpnc_pkg::status_type e_st;
      logic [6:0]           e_dep;
   } row_type;

   typedef struct {
      logic signed [31:0] val;
      logic [1:0]         st;
      logic [6:0]         dep;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [3:0] req_action = '0;
   logic signed [31:0] req_operand_value = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_result_value;
   logic [1:0] rsp_status;
   logic [6:0] rsp_depth;

   logic signed [31:0] calc_stack [rpnc_pkg::StackDepth];
   int unsigned calc_depth;
   answer_type pending_answers[$];
   int mismatches = 0;
   int fails = 0;

   rpn_stack_calculator_q16_core u_top (.*);

   // Clock generator.
   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog.
   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [63:0] magnitude(logic signed [31:0] v);
      return v < 0 ? 64'(-64'(v)) : 64'(v);
   endfunction

   function automatic logic signed [31:0] saturate_mag(bit neg, logic [63:0] m);
      if (neg) return (m >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-m);
      return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(m);
   endfunction

   function automatic logic signed [31:0] saturate64(logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return 32'(v);
   endfunction

   // Predicts one command and advances the calculator state.
   function automatic answer_type calculate(logic [3:0] act, logic signed [31:0] v);
      answer_type ans;
      logic signed [31:0] a, b, r, t;
      bit neg, popped;
      ans.st = rpnc_pkg::ST_OK;
      popped = 0;
      r = '0;
      case (act)
         rpnc_pkg::ACT_ADD, rpnc_pkg::ACT_SUB, rpnc_pkg::ACT_MUL, rpnc_pkg::ACT_DIV,
         rpnc_pkg::ACT_REM: begin
            if (calc_depth < 2) ans.st = rpnc_pkg::ST_UNDERFLOW;
            else begin
               a = calc_stack[calc_depth-2];
               b = calc_stack[calc_depth-1];
               neg = (a < 0) != (b < 0);
               if ((act == rpnc_pkg::ACT_DIV || act == rpnc_pkg::ACT_REM) && b == 0) begin
                  calc_depth--;
                  ans.st = rpnc_pkg::ST_DIVZERO;
               end else begin
                  case (act)
                     rpnc_pkg::ACT_ADD: r = saturate64(64'(a) + 64'(b));
                     rpnc_pkg::ACT_SUB: r = saturate64(64'(a) - 64'(b));
                     rpnc_pkg::ACT_MUL: r = saturate_mag(neg,
                        (magnitude(a) * magnitude(b)) >> rpnc_pkg::FracBits);
                     rpnc_pkg::ACT_DIV: r = saturate_mag(neg,
                        (magnitude(a) << rpnc_pkg::FracBits) / magnitude(b));
                     default: r = saturate_mag(a < 0, magnitude(a) % magnitude(b));
                  endcase
                  calc_depth -= 1;
                  calc_stack[calc_depth-1] = r;
               end
            end
         end
         rpnc_pkg::ACT_PUSH: begin
            if (calc_depth < rpnc_pkg::StackDepth) begin
               calc_stack[calc_depth] = v;
               calc_depth++;
            end else ans.st = rpnc_pkg::ST_FULL;
         end
         rpnc_pkg::ACT_POP: begin
            popped = 1;
            ans.val = '0;
            if (calc_depth == 0) ans.st = rpnc_pkg::ST_UNDERFLOW;
            else begin
               calc_depth--;
               ans.val = calc_stack[calc_depth];
            end
         end
         rpnc_pkg::ACT_PEEK: if (calc_depth == 0) ans.st = rpnc_pkg::ST_UNDERFLOW;
         rpnc_pkg::ACT_DUP: begin
            if (calc_depth == 0) ans.st = rpnc_pkg::ST_UNDERFLOW;
            else if (calc_depth >= rpnc_pkg::StackDepth) ans.st = rpnc_pkg::ST_FULL;
            else begin
               calc_stack[calc_depth] = calc_stack[calc_depth-1];
               calc_depth++;
            end
         end
         rpnc_pkg::ACT_SWAP: begin
            if (calc_depth < 2) ans.st = rpnc_pkg::ST_UNDERFLOW;
            else begin
               t = calc_stack[calc_depth-1];
               calc_stack[calc_depth-1] = calc_stack[calc_depth-2];
               calc_stack[calc_depth-2] = t;
            end
         end
         rpnc_pkg::ACT_CLEAR: calc_depth = 0;
         default: ;
      endcase
      if (!popped) ans.val = calc_depth > 0 ? calc_stack[calc_depth-1] : '0;
      ans.dep = 7'(calc_depth);
      return ans;
   endfunction

   // Result checker: each strobe is compared with the oldest expectation.
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            fails++;
            if (mismatches++ < 10) $display("unexpected transaction: %h %0d %0d",
               rsp_result_value, rsp_status, rsp_depth);
         end else begin
            e = pending_answers.pop_front();
            if (rsp_result_value !== e.val || rsp_status !== e.st || rsp_depth !== e.dep) begin
               fails++;
               if (mismatches++ < 10)
                  $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                     e.val, e.st, e.dep, rsp_result_value, rsp_status, rsp_depth);
            end
         end
      end
   end

   // Issues one command, optionally idling first, and queues its expectation.
   task automatic issue(logic [3:0] act, logic signed [31:0] v, bit idle_ok,
                        bit chk, answer_type typed);
      answer_type ans;
      if (idle_ok) begin
         while ($urandom_range(99) < 18) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_operand_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      ans = calculate(act, v);
      if (chk && (ans.val !== typed.val || ans.st !== typed.st || ans.dep !== typed.dep))
         $display("directed row disagrees with prediction");
      pending_answers.push_back(chk ? typed : ans);
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sd0;
         3: return 32'($urandom_range(65536*8)) - 32'sd262144;
         default: return $urandom;
      endcase
   endfunction

   row_type dir_rows[$];

   task automatic add_row(logic [3:0] act, logic signed [31:0] v, bit chk = 0,
                          logic signed [31:0] ev = 0,
                          rpnc_pkg::status_type es = rpnc_pkg::ST_OK,
                          logic [6:0] ed = 0);
      row_type r;
      r.act = act; r.val = v; r.chk = chk; r.e_val = ev; r.e_st = es; r.e_dep = ed;
      dir_rows.push_back(r);
   endtask

   initial begin
      answer_type typed;
      logic [3:0] act;
      int n, k;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty-stack cases, extremes, saturation, divide by zero, unknown action, clear.
      add_row(rpnc_pkg::ACT_POP, 0, 1, 0, rpnc_pkg::ST_UNDERFLOW, 0);
      add_row(rpnc_pkg::ACT_PEEK, 0, 1, 0, rpnc_pkg::ST_UNDERFLOW, 0);
      add_row(rpnc_pkg::ACT_DUP, 0, 1, 0, rpnc_pkg::ST_UNDERFLOW, 0);
      add_row(rpnc_pkg::ACT_ADD, 0, 1, 0, rpnc_pkg::ST_UNDERFLOW, 0);
      add_row(rpnc_pkg::ACT_PUSH, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, rpnc_pkg::ST_OK, 1);
      add_row(rpnc_pkg::ACT_SWAP, 0, 1, 32'sh7FFF_FFFF, rpnc_pkg::ST_UNDERFLOW, 1);
      add_row(rpnc_pkg::ACT_DUP, 0, 1, 32'sh7FFF_FFFF, rpnc_pkg::ST_OK, 2);
      add_row(rpnc_pkg::ACT_ADD, 0, 1, 32'sh7FFF_FFFF, rpnc_pkg::ST_OK, 1);
      add_row(rpnc_pkg::ACT_PUSH, 32'sh8000_0000, 1, 32'sh8000_0000, rpnc_pkg::ST_OK, 2);
      add_row(rpnc_pkg::ACT_SWAP, 0);
      add_row(rpnc_pkg::ACT_SUB, 0, 1, 32'sh8000_0000, rpnc_pkg::ST_OK, 1);
      add_row(rpnc_pkg::ACT_PUSH, 0, 1, 0, rpnc_pkg::ST_OK, 2);
      add_row(rpnc_pkg::ACT_DIV, 0, 1, 32'sh8000_0000, rpnc_pkg::ST_DIVZERO, 1);
      add_row(rpnc_pkg::ACT_PUSH, 0);
      add_row(rpnc_pkg::ACT_REM, 0, 1, 32'sh8000_0000, rpnc_pkg::ST_DIVZERO, 1);
      add_row(rpnc_pkg::ACT_PUSH, -32'sh0003_0000);
      add_row(rpnc_pkg::ACT_MUL, 0);
      add_row(rpnc_pkg::ACT_PUSH, 32'sh0002_8000);
      add_row(rpnc_pkg::ACT_DIV, 0);
      add_row(rpnc_pkg::ACT_PUSH, -32'sh0007_0000);
      add_row(rpnc_pkg::ACT_PUSH, 32'sh0002_0000);
      add_row(rpnc_pkg::ACT_REM, 0);
      add_row(4'd15, 32'sh1234_5678);
      add_row(rpnc_pkg::ACT_CLEAR, 0, 1, 0, rpnc_pkg::ST_OK, 0);
      foreach (dir_rows[i]) begin
         typed.val = dir_rows[i].e_val; typed.st = dir_rows[i].e_st;
         typed.dep = dir_rows[i].e_dep;
         issue(dir_rows[i].act, dir_rows[i].val, 1, dir_rows[i].chk, typed);
      end

      // Fill to full and overflow, then drain past empty.
      for (k = 0; k < rpnc_pkg::StackDepth + 2; k++)
         issue(rpnc_pkg::ACT_PUSH, $urandom, 0, 0, typed);
      issue(rpnc_pkg::ACT_DUP, 0, 0, 0, typed);
      for (k = 0; k < rpnc_pkg::StackDepth + 1; k++)
         issue(rpnc_pkg::ACT_POP, 0, k > 20, 0, typed);

      // Random part, mostly pushes and arithmetic, with stack operations and rare clears or unknown actions.
      for (n = 0; n < 700; n++) begin
         k = $urandom_range(99);
         if (k < 35) act = rpnc_pkg::ACT_PUSH;
         else if (k < 80) act = 4'($urandom_range(rpnc_pkg::ACT_REM, rpnc_pkg::ACT_ADD));
         else if (k < 98) act = 4'($urandom_range(rpnc_pkg::ACT_SWAP, rpnc_pkg::ACT_POP));
         else act = 4'($urandom_range(15, rpnc_pkg::ACT_CLEAR));
         issue(act, random_value(), !(n >= 300 && n < 450), 0, typed);
      end

      k = 0;
      while (pending_answers.size() != 0 && k < 1000) begin
         @(posedge clock);
         k++;
      end
      repeat (80) @(posedge clock);
      if (fails == 0 && pending_answers.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
